### rtl/brb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the block ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int MAX_BLOCKS_DEF      = 16;
    localparam int MAX_BLOCK_BYTES_DEF = 256;

    localparam int SIZE_W      = 9;
    localparam int COUNT_W     = 5;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 2;

    localparam int SIZE_RESET_VAL  = 256;
    localparam int COUNT_RESET_VAL = 16;
    localparam int COUNT_MIN       = 2;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_in;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_taken;
        logic [3:0] blocks_available;
        logic       collision;
        logic       collision_error;
    } t_out_item;

    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [7:0] wdata;
    } t_mem_cmd;

endpackage

### rtl/brb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_store
// Byte store with one address shared by a write and a read port, registered read
// data, and a zeroing sweep after reset or on request.
// ----------------------------------------------------------------------------
module brb_store #(
    parameter int DEPTH = brb_pkg::MAX_BLOCKS_DEF * brb_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  brb_pkg::t_mem_cmd  i_cmd,
    input  logic [AW-1:0]      i_addr,
    output logic [7:0]         o_rdata,
    output logic               o_busy
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= 8'd0;
        end else if (i_cmd.wr) begin
            mem[i_addr] <= i_cmd.wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### rtl/block_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_ring_buffer
// Ring of fixed-size byte blocks, written and read one byte per beat.
// ----------------------------------------------------------------------------
// One input beat is taken per clock cycle while o_in_stall is low; its result
// beat passes through the store's registered read and then the output register.
// The pointers and flags update in the cycle a beat is taken, and the status of
// a result is taken from them as the result moves to the output, so back-to-back
// beats see each other's effects. After reset and after every register write
// that is not ignored (a nonzero value in the used bits of block_size or
// block_count) the store of MAX_BLOCKS * MAX_BLOCK_BYTES bytes (4096 by default)
// is zeroed one byte per cycle, and input beats are stalled until it is done.
module block_ring_buffer #(
    parameter int MAX_BLOCKS      = brb_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_BLOCK_BYTES = brb_pkg::MAX_BLOCK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  brb_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output brb_pkg::t_out_item              o_out,
    input  logic                            i_cfg_we,
    input  logic [brb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [brb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DEPTH = MAX_BLOCKS * MAX_BLOCK_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BLOCKS);
    localparam int CNTW  = BW + 1;
    localparam int SW    = brb_pkg::SIZE_W;
    localparam int COUNT_W_LOCAL = brb_pkg::COUNT_W;
    localparam int SIZE_RESET  = (brb_pkg::SIZE_RESET_VAL > MAX_BLOCK_BYTES) ?
                                 MAX_BLOCK_BYTES : brb_pkg::SIZE_RESET_VAL;
    localparam int COUNT_RESET = (brb_pkg::COUNT_RESET_VAL > MAX_BLOCKS) ?
                                 MAX_BLOCKS : brb_pkg::COUNT_RESET_VAL;

    // Configuration and ring state.
    logic [SW-1:0]   r_block_size,  n_block_size;
    logic [CNTW-1:0] r_block_count, n_block_count;
    logic [BW-1:0]   r_read_block,  n_read_block;
    logic [BW-1:0]   r_write_block, n_write_block;
    logic [BW-1:0]   r_next_wblock, n_next_wblock;
    logic [AW-1:0]   r_read_base,   n_read_base;
    logic [AW-1:0]   r_write_base,  n_write_base;
    logic [SW-1:0]   r_read_pos,    n_read_pos;
    logic [SW-1:0]   r_write_pos,   n_write_pos;
    logic            r_write_open,  n_write_open;
    logic            r_write_refused, n_write_refused;
    logic            r_read_open,   n_read_open;
    logic            r_read_refused, n_read_refused;
    logic            r_full,        n_full;
    logic            r_refusal,     n_refusal;

    // Result pipeline.
    logic               r_s1_valid;
    logic               r_s1_taken, n_s1_taken;
    logic               r_s1_rvalid, n_s1_rvalid;
    logic               r_out_valid;
    brb_pkg::t_out_item r_out;

    logic              in_accept;
    logic              s1_go;
    logic              store_busy;
    logic [7:0]        store_rdata;
    brb_pkg::t_mem_cmd mem_cmd;
    logic [AW-1:0]     mem_addr;

    logic              cfg_size_wr;
    logic              cfg_count_wr;
    logic              cfg_restart;
    logic [SW-1:0]     cfg_size;
    logic [COUNT_W_LOCAL-1:0] cfg_count_raw;
    logic [CNTW-1:0]   cfg_count;

    logic [CNTW-1:0]   avail;
    logic [31:0]       avail_ext;
    logic [CNTW-1:0]   wb_inc;
    logic [CNTW-1:0]   nwb_inc;
    logic [CNTW-1:0]   rb_inc;
    logic              wb_wrap;
    logic              nwb_wrap;
    logic              rb_wrap;
    logic [BW-1:0]     adv_next_wblock;
    logic [AW-1:0]     adv_write_base;
    logic [AW-1:0]     adv_read_base;
    logic              v_wrefused;
    logic [SW-1:0]     v_wpos;
    logic              v_rrefused;
    logic [SW-1:0]     v_rpos;
    logic [31:0]       v_waddr;
    logic [31:0]       v_raddr;

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = store_busy || (r_s1_valid && !s1_go);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Register writes: a zero value is ignored, others are clamped.
    assign cfg_size_wr  = i_cfg_we && (i_cfg_index == brb_pkg::REG_BLOCK_SIZE) &&
                          (i_cfg_data[SW-1:0] != '0);
    assign cfg_count_raw = i_cfg_data[COUNT_W_LOCAL-1:0];
    assign cfg_count_wr = i_cfg_we && (i_cfg_index == brb_pkg::REG_BLOCK_COUNT) &&
                          (cfg_count_raw != '0);
    assign cfg_restart  = cfg_size_wr || cfg_count_wr;
    assign cfg_size     = (32'(i_cfg_data[SW-1:0]) > 32'(MAX_BLOCK_BYTES)) ?
                          SW'(MAX_BLOCK_BYTES) : i_cfg_data[SW-1:0];

    always_comb begin
        if (32'(cfg_count_raw) > 32'(MAX_BLOCKS)) begin
            cfg_count = CNTW'(MAX_BLOCKS);
        end else if (32'(cfg_count_raw) < 32'(brb_pkg::COUNT_MIN)) begin
            cfg_count = CNTW'(brb_pkg::COUNT_MIN);
        end else begin
            cfg_count = CNTW'(cfg_count_raw);
        end
    end

    // Complete unread blocks in the current state.
    always_comb begin
        if (r_write_block >= r_read_block) begin
            avail = CNTW'(r_write_block) - CNTW'(r_read_block);
        end else begin
            avail = r_block_count + CNTW'(r_write_block) - CNTW'(r_read_block);
        end
    end
    assign avail_ext = 32'(avail);

    // Pointer advance with wrap.
    assign wb_inc   = CNTW'(r_write_block) + 1'b1;
    assign nwb_inc  = CNTW'(r_next_wblock) + 1'b1;
    assign rb_inc   = CNTW'(r_read_block) + 1'b1;
    assign wb_wrap  = wb_inc >= r_block_count;
    assign nwb_wrap = nwb_inc >= r_block_count;
    assign rb_wrap  = rb_inc >= r_block_count;
    assign adv_next_wblock = nwb_wrap ? '0 : nwb_inc[BW-1:0];
    assign adv_write_base  = wb_wrap ? '0 :
                             AW'(32'(r_write_base) + 32'(r_block_size));
    assign adv_read_base   = rb_wrap ? '0 :
                             AW'(32'(r_read_base) + 32'(r_block_size));

    // A transfer that is not open starts at position zero.
    assign v_wrefused = r_write_open ? r_write_refused : r_full;
    assign v_wpos     = r_write_open ? r_write_pos : '0;
    assign v_rrefused = r_read_open ? r_read_refused : (avail == '0);
    assign v_rpos     = r_read_open ? r_read_pos : '0;
    assign v_waddr    = 32'(r_write_base) + 32'(v_wpos);
    assign v_raddr    = 32'(r_read_base) + 32'(v_rpos);

    always_comb begin
        n_block_size    = r_block_size;
        n_block_count   = r_block_count;
        n_read_block    = r_read_block;
        n_write_block   = r_write_block;
        n_next_wblock   = r_next_wblock;
        n_read_base     = r_read_base;
        n_write_base    = r_write_base;
        n_read_pos      = r_read_pos;
        n_write_pos     = r_write_pos;
        n_write_open    = r_write_open;
        n_write_refused = r_write_refused;
        n_read_open     = r_read_open;
        n_read_refused  = r_read_refused;
        n_full          = r_full;
        n_refusal       = r_refusal;
        n_s1_taken      = 1'b0;
        n_s1_rvalid     = 1'b0;
        mem_cmd.wr      = 1'b0;
        mem_cmd.rd      = 1'b0;
        mem_cmd.wdata   = i_in.data_in;
        mem_addr        = v_waddr[AW-1:0];

        if (in_accept) begin
            case (i_in.action)
                brb_pkg::ACT_WRITE: begin
                    n_write_open    = 1'b1;
                    n_write_refused = v_wrefused;
                    n_write_pos     = v_wpos;
                    if (!r_write_open && r_full) begin
                        n_refusal = 1'b1;
                    end
                    if (!v_wrefused && (v_wpos < r_block_size)) begin
                        mem_cmd.wr  = 1'b1;
                        n_write_pos = v_wpos + 1'b1;
                        n_s1_taken  = 1'b1;
                    end
                    if (i_in.last) begin
                        n_write_open = 1'b0;
                        if (!v_wrefused) begin
                            n_write_block = wb_wrap ? '0 : wb_inc[BW-1:0];
                            n_write_base  = adv_write_base;
                            n_next_wblock = adv_next_wblock;
                            if (adv_next_wblock == r_read_block) begin
                                n_full = 1'b1;
                            end
                        end
                    end
                end
                brb_pkg::ACT_READ: begin
                    n_read_open    = 1'b1;
                    n_read_refused = v_rrefused;
                    n_read_pos     = v_rpos;
                    mem_addr       = v_raddr[AW-1:0];
                    if (!v_rrefused && (v_rpos < r_block_size)) begin
                        mem_cmd.rd  = 1'b1;
                        n_read_pos  = v_rpos + 1'b1;
                        n_s1_rvalid = 1'b1;
                    end
                    if (i_in.last) begin
                        n_read_open = 1'b0;
                        if (!v_rrefused) begin
                            n_read_block = rb_wrap ? '0 : rb_inc[BW-1:0];
                            n_read_base  = adv_read_base;
                            n_full       = 1'b0;
                            n_refusal    = 1'b0;
                        end
                    end
                end
                brb_pkg::ACT_CLEAR: begin
                    n_read_block = r_write_block;
                    n_read_base  = r_write_base;
                    n_read_open  = 1'b0;
                    n_read_pos   = '0;
                end
                default: begin
                end
            endcase
        end

        if (cfg_size_wr) begin
            n_block_size = cfg_size;
        end
        if (cfg_count_wr) begin
            n_block_count = cfg_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            if (!i_rst_n) begin
                r_block_size  <= SW'(SIZE_RESET);
                r_block_count <= CNTW'(COUNT_RESET);
            end else begin
                r_block_size  <= n_block_size;
                r_block_count <= n_block_count;
            end
            r_read_block    <= '0;
            r_write_block   <= '0;
            r_next_wblock   <= BW'(1);
            r_read_base     <= '0;
            r_write_base    <= '0;
            r_read_pos      <= '0;
            r_write_pos     <= '0;
            r_write_open    <= 1'b0;
            r_write_refused <= 1'b0;
            r_read_open     <= 1'b0;
            r_read_refused  <= 1'b0;
            r_full          <= 1'b0;
            r_refusal       <= 1'b0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_block_size    <= n_block_size;
            r_block_count   <= n_block_count;
            r_read_block    <= n_read_block;
            r_write_block   <= n_write_block;
            r_next_wblock   <= n_next_wblock;
            r_read_base     <= n_read_base;
            r_write_base    <= n_write_base;
            r_read_pos      <= n_read_pos;
            r_write_pos     <= n_write_pos;
            r_write_open    <= n_write_open;
            r_write_refused <= n_write_refused;
            r_read_open     <= n_read_open;
            r_read_refused  <= n_read_refused;
            r_full          <= n_full;
            r_refusal       <= n_refusal;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. The status reflects the state left by the beat in
    // stage one, since nothing newer has been taken while it waits.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_taken  <= n_s1_taken;
            r_s1_rvalid <= n_s1_rvalid;
        end
        if (s1_go) begin
            r_out.read_data        <= r_s1_rvalid ? store_rdata : 8'd0;
            r_out.read_valid       <= r_s1_rvalid;
            r_out.write_taken      <= r_s1_taken;
            r_out.blocks_available <= avail_ext[3:0];
            r_out.collision        <= r_full;
            r_out.collision_error  <= r_refusal;
        end
    end

    brb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_restart),
        .i_cmd     (mem_cmd),
        .i_addr    (mem_addr),
        .o_rdata   (store_rdata),
        .o_busy    (store_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_avail_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avail < r_block_count)
        else $error("unread block count reached the ring size");

    a_blocks_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_write_block < r_block_count) && (r_read_block < r_block_count))
        else $error("block pointer outside the ring");

    a_no_accept_while_zeroing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_busy |-> !in_accept)
        else $error("beat taken while the store is being zeroed");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n || cfg_restart)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_rvalid)))
        else $error("waiting result lost before reaching the output");

    a_one_kind_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.read_valid && r_out.write_taken))
        else $error("result claims both a read and a write");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block ring buffer.
// ----------------------------------------------------------------------------
// A short directed run covers refused reads and writes, short and overlong
// blocks, clears in open transfers and the unused action. Randomized block
// transfers follow under several ring settings. Every accepted input beat is
// fed to a tracker that keeps its own copy of the ring and queues the status
// beat it should produce. Every output beat is checked field by field against
// the oldest queued one. Both sides stall and idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0]                    ACT_NONE     = 2'd3;
    localparam logic [brb_pkg::CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
    localparam logic [brb_pkg::CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;
    localparam int                            LIMIT_CYCLES = 400000;
    localparam int                            HOLD_CYCLES  = 40;

    class ring_tracker;
        logic [7:0]  store [0:brb_pkg::MAX_BLOCKS_DEF*brb_pkg::MAX_BLOCK_BYTES_DEF-1];
        int unsigned blk_size, blk_count;
        int unsigned rd_blk, wr_blk, nxt_blk, rd_base, wr_base, rd_pos, wr_pos;
        bit          wr_open, wr_skip, rd_open, rd_skip, full, overrun;
        brb_pkg::t_out_item due [$];
        int unsigned mismatches, checked, delivered, refusals;

        function new();
            blk_size   = brb_pkg::SIZE_RESET_VAL;
            blk_count  = brb_pkg::COUNT_RESET_VAL;
            mismatches = 0;
            checked    = 0;
            delivered  = 0;
            refusals   = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (store[i]) store[i] = 8'h00;
            rd_blk  = 0;
            wr_blk  = 0;
            nxt_blk = 1;
            rd_base = 0;
            wr_base = 0;
            rd_pos  = 0;
            wr_pos  = 0;
            wr_open = 0;
            wr_skip = 0;
            rd_open = 0;
            rd_skip = 0;
            full    = 0;
            overrun = 0;
        endfunction

        function int unsigned unread();
            if (wr_blk >= rd_blk) return wr_blk - rd_blk;
            return blk_count + wr_blk - rd_blk;
        endfunction

        // Returns 1 when the write restarts the ring (and the store clear).
        function bit set_reg(logic [brb_pkg::CFG_IDX_W-1:0] idx,
                             logic [brb_pkg::CFG_DATA_W-1:0] val);
            int unsigned v;
            case (idx)
                brb_pkg::REG_BLOCK_SIZE: begin
                    v = val;
                    if (v == 0) return 0;
                    blk_size = (v > brb_pkg::MAX_BLOCK_BYTES_DEF) ?
                               brb_pkg::MAX_BLOCK_BYTES_DEF : v;
                end
                brb_pkg::REG_BLOCK_COUNT: begin
                    v = val[brb_pkg::COUNT_W-1:0];
                    if (v == 0) return 0;
                    if (v < brb_pkg::COUNT_MIN) v = brb_pkg::COUNT_MIN;
                    blk_count = (v > brb_pkg::MAX_BLOCKS_DEF) ? brb_pkg::MAX_BLOCKS_DEF : v;
                end
                default: return 0;
            endcase
            wipe();
            return 1;
        endfunction

        function void take_byte(brb_pkg::t_in_item b);
            brb_pkg::t_out_item r;
            int        avail;
            r = '0;
            case (b.action)
                brb_pkg::ACT_WRITE: begin
                    if (!wr_open) begin
                        wr_open = 1;
                        wr_pos  = 0;
                        wr_skip = full;
                        if (full) begin
                            overrun = 1;
                            refusals++;
                        end
                    end
                    if (!wr_skip && wr_pos < blk_size) begin
                        store[wr_base + wr_pos] = b.data_in;
                        wr_pos++;
                        r.write_taken = 1'b1;
                    end
                    if (b.last) begin
                        wr_open = 0;
                        if (!wr_skip) begin
                            wr_blk++;
                            wr_base += blk_size;
                            if (wr_blk >= blk_count) begin
                                wr_blk  = 0;
                                wr_base = 0;
                            end
                            nxt_blk++;
                            if (nxt_blk >= blk_count) nxt_blk = 0;
                            if (nxt_blk == rd_blk) full = 1;
                        end
                    end
                end
                brb_pkg::ACT_READ: begin
                    if (!rd_open) begin
                        rd_open = 1;
                        rd_pos  = 0;
                        rd_skip = (unread() == 0);
                    end
                    if (!rd_skip && rd_pos < blk_size) begin
                        r.read_data  = store[rd_base + rd_pos];
                        r.read_valid = 1'b1;
                        rd_pos++;
                        delivered++;
                    end
                    if (b.last) begin
                        rd_open = 0;
                        if (!rd_skip) begin
                            rd_blk++;
                            rd_base += blk_size;
                            if (rd_blk >= blk_count) begin
                                rd_blk  = 0;
                                rd_base = 0;
                            end
                            full    = 0;
                            overrun = 0;
                        end
                    end
                end
                brb_pkg::ACT_CLEAR: begin
                    // Drop every unread block; an open write carries on.
                    rd_blk  = wr_blk;
                    rd_base = wr_base;
                    rd_open = 0;
                    rd_pos  = 0;
                end
                default: ;
            endcase
            avail                = unread();
            r.blocks_available   = avail[3:0];
            r.collision          = full;
            r.collision_error    = overrun;
            due.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_reply(brb_pkg::t_out_item got);
            brb_pkg::t_out_item want;
            if (due.size() == 0) begin
                mismatches++;
                $display("%0t: status beat with none expected, got %p", $time, got);
                return;
            end
            want = due.pop_front();
            checked++;
            check_field("read_data", want.read_data, got.read_data);
            check_field("read_valid", want.read_valid, got.read_valid);
            check_field("write_taken", want.write_taken, got.write_taken);
            check_field("blocks_available", want.blocks_available, got.blocks_available);
            check_field("collision", want.collision, got.collision);
            check_field("collision_error", want.collision_error, got.collision_error);
        endfunction
    endclass

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    brb_pkg::t_in_item              i_in        = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    brb_pkg::t_out_item             o_out;
    logic                           i_cfg_we    = 1'b0;
    logic [brb_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [brb_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    ring_tracker tracker;
    bit          quiet         = 0;
    bit          hold_req      = 0;
    int          hold_left     = 0;
    int          stall_left    = 0;
    int          beats_sent    = 0;
    int          write_share   = 45;
    int          settings_used = 1;
    int          cycles        = 0;

    block_ring_buffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("** block_ring_buffer: FAILED **");
            $finish;
        end
    end

    // Output side: check accepted beats, then decide the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.match_reply(o_out);
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_beat(input logic [1:0] act, input logic [7:0] data, input logic last);
        brb_pkg::t_in_item b;
        b.action  = act;
        b.data_in = data;
        b.last    = last;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_byte(b);
        beats_sent++;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (tracker.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain_replies();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [brb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [brb_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (tracker.set_reg(idx, val)) begin
            // The store is being cleared; let that finish before anything else.
            repeat (2) @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
    endtask

    function automatic int block_len();
        int sz;
        sz = tracker.blk_size;
        if (sz <= 16) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: return sz;
                5, 6:          return sz + $urandom_range(1, 2);
                default:       return $urandom_range(1, sz);
            endcase
        end
        if ($urandom_range(0, 11) == 0) return sz + $urandom_range(0, 2);
        return $urandom_range(1, 6);
    endfunction

    task automatic move_block(input logic [1:0] act);
        int len;
        len = block_len();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                send_beat(brb_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom));
            end
            send_beat(act, 8'($urandom), i == len - 1);
        end
    endtask

    task automatic run_traffic(input int n);
        int stop;
        int pick;
        stop = beats_sent + n;
        while (beats_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < write_share) begin
                move_block(brb_pkg::ACT_WRITE);
            end else if (pick < 85) begin
                move_block(brb_pkg::ACT_READ);
            end else if (pick < 90) begin
                send_beat(brb_pkg::ACT_CLEAR, 8'($urandom), 1'($urandom));
            end else if (pick < 93) begin
                send_beat(ACT_NONE, 8'($urandom), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_beat(2'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic [brb_pkg::CFG_DATA_W-1:0] size_val,
                             input logic [brb_pkg::CFG_DATA_W-1:0] count_val, input int n);
        settle();
        write_reg(brb_pkg::REG_BLOCK_SIZE, size_val);
        write_reg(brb_pkg::REG_BLOCK_COUNT, count_val);
        write_share = $urandom_range(35, 60);
        settings_used++;
        run_traffic(n / 3);
        hold_req = 1;
        run_traffic(n / 3);
        drain_replies();
        run_traffic(n - 2 * (n / 3));
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default ring: refused read, short block, unused action, clears.
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b1);
        send_beat(brb_pkg::ACT_WRITE, 8'h00, 1'b0);
        send_beat(brb_pkg::ACT_WRITE, 8'hFF, 1'b1);
        send_beat(ACT_NONE, 8'hFF, 1'b1);
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b0);
        send_beat(brb_pkg::ACT_CLEAR, 8'h00, 1'b0);
        send_beat(brb_pkg::ACT_READ, 8'hFF, 1'b1);
        send_beat(brb_pkg::ACT_WRITE, 8'h5A, 1'b0);
        send_beat(brb_pkg::ACT_CLEAR, 8'hFF, 1'b1);
        send_beat(brb_pkg::ACT_WRITE, 8'hA5, 1'b1);
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b1);

        // One-byte blocks in a ring of two; the count saturates up from one,
        // and zero values and spare indexes must be ignored.
        settle();
        write_reg(brb_pkg::REG_BLOCK_SIZE, 9'd1);
        write_reg(brb_pkg::REG_BLOCK_COUNT, 9'h041);
        write_reg(brb_pkg::REG_BLOCK_COUNT, 9'h100);
        write_reg(brb_pkg::REG_BLOCK_SIZE, 9'd0);
        write_reg(REG_SPARE_A, 9'h1FF);
        write_reg(REG_SPARE_B, 9'h155);
        settings_used++;
        send_beat(brb_pkg::ACT_WRITE, 8'h11, 1'b0);
        send_beat(brb_pkg::ACT_WRITE, 8'h22, 1'b0);
        send_beat(brb_pkg::ACT_WRITE, 8'h33, 1'b1);
        send_beat(brb_pkg::ACT_WRITE, 8'h44, 1'b1);
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b0);
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b1);
        send_beat(brb_pkg::ACT_READ, 8'h00, 1'b1);

        run_phase(9'd4, 9'd2, 200);
        run_phase(9'd1, 9'd31, 220);
        run_phase(9'd511, 9'd3, 200);
        run_phase(9'd7, 9'd5, 220);
        run_phase(9'd256, 9'd16, 180);
        quiet = 1;
        run_phase(9'd3, 9'd16, 310);

        settle();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d input beats over %0d ring settings, %0d status beats checked.",
                 beats_sent, settings_used, tracker.checked);
        $display("Bytes delivered by reads: %0d; write blocks refused while full: %0d.",
                 tracker.delivered, tracker.refusals);
        if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
            $display("** block_ring_buffer: PASSED **");
        end else begin
            $display("** block_ring_buffer: FAILED **");
        end
        $finish;
    end

endmodule
